[design/serial_frame_buffer_unit_assert.svh]
// Assertion macros used by the serial frame buffer core.
`ifndef SERIAL_FRAME_BUFFER_UNIT_ASSERT_SVH
`define SERIAL_FRAME_BUFFER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SFB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sfb_pkg.sv]
// Shared types and constants for the serial frame buffer.
`default_nettype none

package sfb_pkg;

    // Frame storage size and derived widths
    localparam int BUF_BYTES = 128;
    localparam int ADDR_W    = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
    localparam int CNT_W     = $clog2(BUF_BYTES + 1);
    localparam int POS_W     = ((CNT_W > 8) ? CNT_W : 8) + 1;

    localparam logic [CNT_W-1:0] BUF_FULL = CNT_W'(BUF_BYTES);

    // Idle tick counter saturates at all ones
    localparam int              IDLE_W   = 17;
    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

    // Line framing characters
    localparam logic [7:0] CODE_CR = 8'd13;
    localparam logic [7:0] CODE_LF = 8'd10;

    // Register reset values
    localparam logic        TEXT_MODE_RST  = 1'b1;
    localparam logic [15:0] STOP_TICKS_RST = 16'd100;

    // APB address width: two 32-bit registers
    localparam int PADDR_W = 3;

    typedef enum logic [2:0] {
        OP_RX_BYTE   = 3'd0,
        OP_TICK      = 3'd1,
        OP_READ_NEXT = 3'd2,
        OP_PEEK      = 3'd3,
        OP_CLEAR     = 3'd4
    } sfb_op_t;

    typedef enum logic [PADDR_W-3:0] {
        REG_TEXT_MODE  = 1'b0,
        REG_STOP_TICKS = 1'b1
    } sfb_reg_t;

    typedef struct packed {
        logic        text_mode;
        logic [15:0] stop_ticks;
    } sfb_cfg_t;

    typedef struct packed {
        sfb_op_t    op;
        logic [7:0] rx_byte;
        logic [7:0] peek_offset;
    } sfb_item_t;

    typedef struct packed {
        logic       char_valid;
        logic       byte_refused;
        logic       frame_done;
        logic       overflowed;
        logic [7:0] frame_length;
        logic [7:0] read_position;
    } sfb_status_t;

endpackage

`default_nettype wire

[design/sfb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                                         clk,
    input  wire logic                                         wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                             wr_data,
    input  wire logic                                         rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/sfb_cfg.sv]
// APB register block: text_mode and stop_ticks.
`default_nettype none

module sfb_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sfb_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output sfb_pkg::sfb_cfg_t                cfg
);

    logic              text_mode_reg;
    logic              text_mode_next;
    logic [15:0]       stop_ticks_reg;
    logic [15:0]       stop_ticks_next;
    logic              wr_stb;
    sfb_pkg::sfb_reg_t reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = sfb_pkg::sfb_reg_t'(paddr[sfb_pkg::PADDR_W-1:2]);
    assign wr_stb  = psel & penable & pwrite & pready;

    // Register write decode
    always_comb
    begin
        text_mode_next  = text_mode_reg;
        stop_ticks_next = stop_ticks_reg;
        if (wr_stb)
        begin
            case (reg_sel)
                sfb_pkg::REG_TEXT_MODE:  text_mode_next  = pwdata[0];
                sfb_pkg::REG_STOP_TICKS: stop_ticks_next = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_mode_reg  <= sfb_pkg::TEXT_MODE_RST;
            stop_ticks_reg <= sfb_pkg::STOP_TICKS_RST;
        end
        else
        begin
            text_mode_reg  <= text_mode_next;
            stop_ticks_reg <= stop_ticks_next;
        end
    end

    // Read-back mux
    always_comb
    begin
        case (reg_sel)
            sfb_pkg::REG_TEXT_MODE:  prdata = {31'd0, text_mode_reg};
            sfb_pkg::REG_STOP_TICKS: prdata = {16'd0, stop_ticks_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    assign cfg.text_mode  = text_mode_reg;
    assign cfg.stop_ticks = stop_ticks_reg;

endmodule

`default_nettype wire

[design/sfb_core.sv]
// Frame state: byte collection, framing, read/peek pointer and frame store.
`default_nettype none

`include "serial_frame_buffer_unit_assert.svh"

module sfb_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               proc_en,
    input  wire sfb_pkg::sfb_item_t item,
    input  wire sfb_pkg::sfb_cfg_t  cfg,
    output sfb_pkg::sfb_status_t    status,
    output logic [7:0]              char_data
);

    logic [sfb_pkg::CNT_W-1:0]  count_reg;
    logic [sfb_pkg::CNT_W-1:0]  count_next;
    logic [sfb_pkg::CNT_W-1:0]  rindex_reg;
    logic [sfb_pkg::CNT_W-1:0]  rindex_next;
    logic [sfb_pkg::IDLE_W-1:0] idle_reg;
    logic [sfb_pkg::IDLE_W-1:0] idle_next;
    logic                       done_reg;
    logic                       done_next;
    logic                       overrun_reg;
    logic                       overrun_next;

    logic                       wr_en;
    logic [sfb_pkg::ADDR_W-1:0] wr_addr;
    logic [sfb_pkg::ADDR_W-1:0] rd_addr;
    logic                       char_valid;
    logic                       refused;
    logic [sfb_pkg::POS_W-1:0]  peek_pos;
    logic [sfb_pkg::IDLE_W-1:0] idle_inc;

    assign peek_pos = sfb_pkg::POS_W'(rindex_reg) + sfb_pkg::POS_W'(item.peek_offset);
    assign idle_inc = (idle_reg != sfb_pkg::IDLE_MAX) ? idle_reg + 1'b1 : idle_reg;
    assign wr_addr  = count_reg[sfb_pkg::ADDR_W-1:0];

    // Per-transaction state update
    always_comb
    begin
        count_next   = count_reg;
        rindex_next  = rindex_reg;
        idle_next    = idle_reg;
        done_next    = done_reg;
        overrun_next = overrun_reg;
        wr_en        = 1'b0;
        rd_addr      = '0;
        char_valid   = 1'b0;
        refused      = 1'b0;
        case (item.op)
            sfb_pkg::OP_RX_BYTE:
            begin
                if (done_reg)
                begin
                    refused = 1'b1;
                end
                else
                begin
                    idle_next = '0;
                    if (cfg.text_mode && item.rx_byte == sfb_pkg::CODE_CR)
                    begin
                        // carriage return dropped
                    end
                    else if (cfg.text_mode && item.rx_byte == sfb_pkg::CODE_LF)
                    begin
                        done_next = 1'b1;
                    end
                    else if (count_reg < sfb_pkg::BUF_FULL)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        // overrun: drop byte, empty frame, sticky flag
                        overrun_next = 1'b1;
                        count_next   = '0;
                        rindex_next  = '0;
                        done_next    = 1'b0;
                    end
                end
            end
            sfb_pkg::OP_TICK:
            begin
                if (!done_reg)
                begin
                    idle_next = idle_inc;
                    if (!cfg.text_mode && count_reg != '0
                        && idle_inc > sfb_pkg::IDLE_W'(cfg.stop_ticks))
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            sfb_pkg::OP_READ_NEXT:
            begin
                if (rindex_reg < count_reg)
                begin
                    char_valid  = 1'b1;
                    rd_addr     = rindex_reg[sfb_pkg::ADDR_W-1:0];
                    rindex_next = rindex_reg + 1'b1;
                end
            end
            sfb_pkg::OP_PEEK:
            begin
                if (peek_pos < sfb_pkg::POS_W'(count_reg))
                begin
                    char_valid = 1'b1;
                    rd_addr    = peek_pos[sfb_pkg::ADDR_W-1:0];
                end
            end
            sfb_pkg::OP_CLEAR:
            begin
                count_next   = '0;
                rindex_next  = '0;
                idle_next    = '0;
                done_next    = 1'b0;
                overrun_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            rindex_reg  <= '0;
            idle_reg    <= '0;
            done_reg    <= 1'b0;
            overrun_reg <= 1'b0;
        end
        else if (proc_en)
        begin
            count_reg   <= count_next;
            rindex_reg  <= rindex_next;
            idle_reg    <= idle_next;
            done_reg    <= done_next;
            overrun_reg <= overrun_next;
        end
    end

    // Frame store; read data lands with the result register
    sfb_ram #(
        .WIDTH (8),
        .DEPTH (sfb_pkg::BUF_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en & proc_en),
        .wr_addr (wr_addr),
        .wr_data (item.rx_byte),
        .rd_en   (proc_en),
        .rd_addr (rd_addr),
        .rd_data (char_data)
    );

    // Status after the update
    assign status.char_valid    = char_valid;
    assign status.byte_refused  = refused;
    assign status.frame_done    = done_next;
    assign status.overflowed    = overrun_next;
    assign status.frame_length  = 8'(count_next);
    assign status.read_position = 8'(rindex_next);

    `SFB_ASSERT_SAME(a_count_range, clk, rst_n, 1'b1, count_reg <= sfb_pkg::BUF_FULL,
        "stored count above buffer size")
    `SFB_ASSERT_SAME(a_read_behind, clk, rst_n, 1'b1, rindex_reg <= count_reg,
        "read position past stored count")
    `SFB_ASSERT_NEXT(a_overrun_sticky, clk, rst_n,
        overrun_reg && !(proc_en && item.op == sfb_pkg::OP_CLEAR), overrun_reg,
        "overrun flag cleared without clear transaction")
    `SFB_ASSERT_NEXT(a_refused_hold, clk, rst_n,
        proc_en && item.op == sfb_pkg::OP_RX_BYTE && done_reg,
        $stable(count_reg) && done_reg,
        "refused byte changed the frame")

endmodule

`default_nettype wire

[design/serial_frame_buffer_unit.sv]
// Serial frame buffer: stream in, stream out, APB configuration.
//
// s_* channel: one transaction per item. s_tuser[2:0] = op (receive byte, tick,
// read next, peek, clear); s_tdata carries rx_byte and peek_offset.
// m_* channel: one result transaction per accepted item, in order, with the
// status after that item's update and the byte returned by read/peek.
// APB: register 0 text_mode at 0x0, register 1 stop_ticks at 0x4; pready
// is tied high, writes take effect at the access cycle.
// An accepted item passes the input register, then the result register holding
// the status and frame store read, before its result is offered.
// Throughput: one item per cycle while m_tready is high; the frame store
// has one write and one read port, both used by the single processing stage.
// Stall: while m_tready is low the result register holds and the input
// register still accepts one item; s_tready drops only when both are full.
// Reset clears the frame state, the pipeline valids and the registers to
// text mode with stop_ticks of 100; the frame store itself is not cleared.
`default_nettype none

module serial_frame_buffer_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // Input stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [15:0]                 s_tdata,  // rx_byte[7:0], peek_offset[15:8]
    input  wire logic [2:0]                  s_tuser,  // op[2:0]
    // Result stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [31:0]                      m_tdata,  // char_out[7:0], char_valid[8],
                                                       // byte_refused[9], frame_done[10],
                                                       // overflowed[11], frame_length[19:12],
                                                       // read_position[27:20], zero[31:28]
    // Configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sfb_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    sfb_pkg::sfb_cfg_t    cfg;
    sfb_pkg::sfb_item_t   item_reg;
    sfb_pkg::sfb_status_t status;
    sfb_pkg::sfb_status_t status_reg;
    logic                 in_valid_reg;
    logic                 out_valid_reg;
    logic                 proc_en;
    logic [7:0]           char_data;
    logic [7:0]           char_out;

    // Process the held item when the result register can take it
    assign proc_en  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | proc_en;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc_en)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.op          <= sfb_pkg::sfb_op_t'(s_tuser);
            item_reg.rx_byte     <= s_tdata[7:0];
            item_reg.peek_offset <= s_tdata[15:8];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_en)
        begin
            status_reg <= status;
        end
    end

    sfb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfb_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .proc_en   (proc_en),
        .item      (item_reg),
        .cfg       (cfg),
        .status    (status),
        .char_data (char_data)
    );

    // Byte is zero unless read/peek hit the frame
    assign char_out = status_reg.char_valid ? char_data : 8'd0;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0,
                       status_reg.read_position,
                       status_reg.frame_length,
                       status_reg.overflowed,
                       status_reg.frame_done,
                       status_reg.byte_refused,
                       status_reg.char_valid,
                       char_out};

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for the serial frame buffer unit.
`timescale 1ns / 100ps

module tb_top;

    // Spare op codes that the block must ignore
    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    localparam int ITEM_TARGET = 1050;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 6;

    // Expected contents of one result transaction
    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic       byte_refused;
        logic       frame_done;
        logic       overflowed;
        logic [7:0] frame_length;
        logic [7:0] read_position;
    } frame_status_t;

    logic                        clk;
    logic                        rst_n = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [15:0]                 s_tdata = '0;
    logic [2:0]                  s_tuser = '0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [31:0]                 m_tdata;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [sfb_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    serial_frame_buffer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predictor copy of the registers and frame state
    logic        cfg_text;
    logic [15:0] cfg_stop;
    logic [7:0]  fb_store [0:sfb_pkg::BUF_BYTES-1];
    int          fb_count;
    int          fb_rd;
    int          fb_idle;
    logic        fb_done;
    logic        fb_ovf;

    frame_status_t status_q[$];
    int            err_count = 0;
    int            items_sent = 0;
    int            cycles = 0;

    // Sender burst control
    bit gaps_on = 1'b1;
    int burst_left = 0;

    // Receiver stall control
    int hold_req = 0;
    int hold_left = 0;
    int mode_left = 0;
    int stall_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic void frame_restart();
        fb_count = 0;
        fb_rd = 0;
        fb_idle = 0;
        fb_done = 1'b0;
    endfunction

    // Next status of the frame buffer for one accepted item
    function automatic frame_status_t frame_update(logic [2:0] op, logic [7:0] rx,
                                                   logic [7:0] off);
        frame_status_t st;
        int pos;
        st = '0;
        case (op)
            sfb_pkg::OP_RX_BYTE:
            begin
                if (fb_done)
                    st.byte_refused = 1'b1;
                else
                begin
                    fb_idle = 0;
                    if (cfg_text && rx == sfb_pkg::CODE_CR)
                        ;
                    else if (cfg_text && rx == sfb_pkg::CODE_LF)
                        fb_done = 1'b1;
                    else if (fb_count < sfb_pkg::BUF_BYTES)
                    begin
                        fb_store[fb_count] = rx;
                        fb_count++;
                    end
                    else
                    begin
                        fb_ovf = 1'b1;
                        frame_restart();
                    end
                end
            end
            sfb_pkg::OP_TICK:
            begin
                if (!fb_done)
                begin
                    if (fb_idle < int'(sfb_pkg::IDLE_MAX))
                        fb_idle++;
                    if (!cfg_text && fb_count > 0 && fb_idle > int'(cfg_stop))
                        fb_done = 1'b1;
                end
            end
            sfb_pkg::OP_READ_NEXT:
            begin
                if (fb_rd < fb_count)
                begin
                    st.char_out = fb_store[fb_rd];
                    st.char_valid = 1'b1;
                    fb_rd++;
                end
            end
            sfb_pkg::OP_PEEK:
            begin
                pos = fb_rd + int'(off);
                if (pos < fb_count)
                begin
                    st.char_out = fb_store[pos];
                    st.char_valid = 1'b1;
                end
            end
            sfb_pkg::OP_CLEAR:
            begin
                frame_restart();
                fb_ovf = 1'b0;
            end
            default: ;
        endcase
        st.frame_done = fb_done;
        st.overflowed = fb_ovf;
        st.frame_length = fb_count[7:0];
        st.read_position = fb_rd[7:0];
        return st;
    endfunction

    // Offer one item; the sender works in bursts with random gaps
    task automatic send_item(input logic [2:0] op, input logic [7:0] rx,
                             input logic [7:0] off);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            burst_left = int'($urandom_range(1, 16));
            gap = int'($urandom_range(0, 5));
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {off, rx};
        do
            @(posedge clk);
        while (!s_tready);
        status_q.push_back(frame_update(op, rx, off));
        items_sent++;
    endtask

    // Drop valid and wait until every expected result has come out
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write followed by a read-back of the same register
    task automatic config_write(input sfb_pkg::sfb_reg_t idx, input logic [31:0] val);
        logic [31:0] rd;
        settle();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == sfb_pkg::REG_TEXT_MODE)
            cfg_text = val[0];
        else
            cfg_stop = val[15:0];
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == sfb_pkg::REG_TEXT_MODE && rd[0] !== cfg_text)
        begin
            $display("%0t mismatch text_mode readback: expected %0d, actual %0d",
                     $time, cfg_text, rd[0]);
            err_count++;
        end
        if (idx == sfb_pkg::REG_STOP_TICKS && rd[15:0] !== cfg_stop)
        begin
            $display("%0t mismatch stop_ticks readback: expected %0d, actual %0d",
                     $time, cfg_stop, rd[15:0]);
            err_count++;
        end
    endtask

    // Receiver: stall pattern of its own, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode_left = int'($urandom_range(20, 120));
                case ($urandom_range(0, 4))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 25;
                    3: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            mode_left--;
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        frame_status_t exp_st;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (status_q.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %h", $time, m_tdata);
                err_count++;
            end
            else
            begin
                exp_st = status_q.pop_front();
                check_field("char_out", exp_st.char_out, m_tdata[7:0]);
                check_field("char_valid", exp_st.char_valid, m_tdata[8]);
                check_field("byte_refused", exp_st.byte_refused, m_tdata[9]);
                check_field("frame_done", exp_st.frame_done, m_tdata[10]);
                check_field("overflowed", exp_st.overflowed, m_tdata[11]);
                check_field("frame_length", exp_st.frame_length, m_tdata[19:12]);
                check_field("read_position", exp_st.read_position, m_tdata[27:20]);
            end
        end
    end

    // Empty frames, line framing, reads and peeks past the end, spare ops
    task automatic test_text_directed();
        send_item(sfb_pkg::OP_READ_NEXT, 8'h00, 8'h00);
        send_item(sfb_pkg::OP_PEEK, 8'h00, 8'hFF);
        send_item(sfb_pkg::OP_RX_BYTE, sfb_pkg::CODE_LF, 8'h00);
        send_item(sfb_pkg::OP_RX_BYTE, 8'hFF, 8'h00);
        send_item(sfb_pkg::OP_TICK, 8'h00, 8'h00);
        send_item(sfb_pkg::OP_CLEAR, 8'h00, 8'h00);
        send_item(sfb_pkg::OP_RX_BYTE, 8'h00, 8'hFF);
        send_item(sfb_pkg::OP_RX_BYTE, sfb_pkg::CODE_CR, 8'h00);
        send_item(sfb_pkg::OP_READ_NEXT, 8'h00, 8'h00);
        send_item(sfb_pkg::OP_RX_BYTE, 8'hFF, 8'h00);
        send_item(sfb_pkg::OP_RX_BYTE, 8'h5A, 8'h00);
        send_item(sfb_pkg::OP_RX_BYTE, sfb_pkg::CODE_LF, 8'h00);
        send_item(sfb_pkg::OP_PEEK, 8'hFF, 8'd1);
        send_item(sfb_pkg::OP_PEEK, 8'h00, 8'd2);
        send_item(sfb_pkg::OP_READ_NEXT, 8'h00, 8'h00);
        send_item(sfb_pkg::OP_READ_NEXT, 8'h00, 8'h00);
        send_item(sfb_pkg::OP_READ_NEXT, 8'h00, 8'h00);
        send_item(sfb_pkg::OP_PEEK, 8'h00, 8'h00);
        send_item(OP_SPARE_A, 8'hFF, 8'hFF);
        send_item(OP_SPARE_B, 8'h00, 8'h00);
        send_item(OP_SPARE_C, 8'hA5, 8'h5A);
        send_item(sfb_pkg::OP_CLEAR, 8'h00, 8'h00);
    endtask

    // Idle timeout framing: line codes are data, ticks end the frame
    task automatic test_binary_directed();
        config_write(sfb_pkg::REG_TEXT_MODE, 32'd0);
        config_write(sfb_pkg::REG_STOP_TICKS, 32'd2);
        send_item(sfb_pkg::OP_TICK, 8'h00, 8'h00);
        send_item(sfb_pkg::OP_RX_BYTE, sfb_pkg::CODE_CR, 8'h00);
        send_item(sfb_pkg::OP_RX_BYTE, sfb_pkg::CODE_LF, 8'h00);
        send_item(sfb_pkg::OP_TICK, 8'h00, 8'h00);
        send_item(sfb_pkg::OP_TICK, 8'h00, 8'h00);
        send_item(sfb_pkg::OP_TICK, 8'h00, 8'h00);
        send_item(sfb_pkg::OP_TICK, 8'h00, 8'h00);
        send_item(sfb_pkg::OP_RX_BYTE, 8'h33, 8'h00);
        send_item(sfb_pkg::OP_READ_NEXT, 8'h00, 8'h00);
        send_item(sfb_pkg::OP_PEEK, 8'h00, 8'd0);
        send_item(sfb_pkg::OP_CLEAR, 8'h00, 8'h00);
    endtask

    // Fill the buffer, overrun it, then show the flag is sticky until clear
    task automatic test_overflow();
        config_write(sfb_pkg::REG_STOP_TICKS, 32'd65535);
        repeat (sfb_pkg::BUF_BYTES)
            send_item(sfb_pkg::OP_RX_BYTE, 8'($urandom_range(0, 255)), 8'h00);
        send_item(sfb_pkg::OP_PEEK, 8'h00, 8'd127);
        send_item(sfb_pkg::OP_RX_BYTE, 8'($urandom_range(0, 255)), 8'h00);
        send_item(sfb_pkg::OP_RX_BYTE, 8'h77, 8'h00);
        repeat (3) send_item(sfb_pkg::OP_TICK, 8'h00, 8'h00);
        send_item(sfb_pkg::OP_READ_NEXT, 8'h00, 8'h00);
        send_item(sfb_pkg::OP_READ_NEXT, 8'h00, 8'h00);
        send_item(sfb_pkg::OP_CLEAR, 8'h00, 8'h00);
        send_item(sfb_pkg::OP_RX_BYTE, 8'h01, 8'h00);
    endtask

    // Long receiver hold-off while items keep coming in back to back
    task automatic test_backpressure();
        settle();
        gaps_on = 1'b0;
        hold_req = 300;
        repeat (40)
        begin
            if ($urandom_range(0, 1))
                send_item(sfb_pkg::OP_RX_BYTE, 8'($urandom_range(0, 255)), 8'h00);
            else
                send_item(sfb_pkg::OP_READ_NEXT, 8'h00, 8'h00);
        end
        gaps_on = 1'b1;
    endtask

    // Reads and peeks over a frame of about len bytes, with a stray byte or tick
    task automatic drain_frame(input int len);
        repeat ($urandom_range(1, len + 3))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                    send_item(sfb_pkg::OP_READ_NEXT, 8'($urandom_range(0, 255)), 8'h00);
                5, 6, 7: send_item(sfb_pkg::OP_PEEK, 8'h00, 8'($urandom_range(0, len)));
                8: send_item(sfb_pkg::OP_PEEK, 8'h00, 8'($urandom_range(0, 255)));
                default:
                    if ($urandom_range(0, 1))
                        send_item(sfb_pkg::OP_RX_BYTE, 8'($urandom_range(0, 255)), 8'h00);
                    else
                        send_item(sfb_pkg::OP_TICK, 8'h00, 8'h00);
            endcase
        end
    endtask

    task automatic text_frame();
        int len;
        logic [7:0] b;
        len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(20, 60))
                                          : int'($urandom_range(0, 12));
        send_item(sfb_pkg::OP_CLEAR, 8'h00, 8'h00);
        repeat (len)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == sfb_pkg::CODE_LF || $urandom_range(0, 7) == 0)
                b = sfb_pkg::CODE_CR;
            send_item(sfb_pkg::OP_RX_BYTE, b, 8'h00);
        end
        if ($urandom_range(0, 7) != 0)
            send_item(sfb_pkg::OP_RX_BYTE, sfb_pkg::CODE_LF, 8'h00);
        drain_frame(len);
    endtask

    task automatic binary_frame();
        int len;
        int nticks;
        len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(20, 60))
                                          : int'($urandom_range(0, 12));
        send_item(sfb_pkg::OP_CLEAR, 8'h00, 8'h00);
        repeat (len) send_item(sfb_pkg::OP_RX_BYTE, 8'($urandom_range(0, 255)), 8'h00);
        nticks = (cfg_stop <= 8) ? int'(cfg_stop) + int'($urandom_range(0, 3))
                                 : int'($urandom_range(0, 4));
        repeat (nticks)
        begin
            if ($urandom_range(0, 15) == 0)
                send_item(sfb_pkg::OP_RX_BYTE, 8'($urandom_range(0, 255)), 8'h00);
            send_item(sfb_pkg::OP_TICK, 8'h00, 8'h00);
        end
        drain_frame(len);
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(4, 12))
            send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
    endtask

    // Frames with random content across several register settings
    task automatic test_random_frames();
        logic        ph_text [8] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
        logic [15:0] ph_stop [8] = '{16'd100, 16'd0, 16'd3, 16'd0, 16'd1, 16'd65535,
                                     16'd7, 16'd65535};
        int ph;
        ph = 0;
        while (items_sent < ITEM_TARGET)
        begin
            config_write(sfb_pkg::REG_TEXT_MODE, {31'd0, ph_text[ph]});
            config_write(sfb_pkg::REG_STOP_TICKS, {16'd0, ph_stop[ph]});
            repeat (6)
            begin
                if ($urandom_range(0, 9) < 2)
                    noise_burst();
                else if (cfg_text)
                    text_frame();
                else
                    binary_frame();
            end
            ph = (ph + 1) % 8;
        end
    endtask

    initial
    begin
        cfg_text = sfb_pkg::TEXT_MODE_RST;
        cfg_stop = sfb_pkg::STOP_TICKS_RST;
        fb_ovf = 1'b0;
        frame_restart();
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_text_directed();
        test_binary_directed();
        test_overflow();
        test_backpressure();
        test_random_frames();

        settle();
        repeat (10) @(posedge clk);
        if (status_q.size() != 0)
        begin
            $display("%0t missing results: expected %0d more, actual 0", $time,
                     status_q.size());
            err_count++;
        end
        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
